// ===== design/prtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prtc_pkg
// Shared types and codes for the packet rule table classifier.
// ----------------------------------------------------------------------------
package prtc_pkg;

   localparam int unsigned PRTC_MAX_RULES = 16;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   typedef enum logic [2:0] {
      MODE_ADD    = 3'd0,
      MODE_DELETE = 3'd1,
      MODE_MATCH  = 3'd2,
      MODE_BLACK  = 3'd3,
      MODE_WHITE  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   // One stored rule; a zero field matches anything.
   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  proto;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic        verdict;
   } rule_type;

   // Header fields of the packet being classified.
   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  proto;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } pkt_type;

   typedef struct packed {
      logic verdict;
      logic stop;
   } eval_type;

endpackage
`default_nettype wire

// ===== design/prtc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prtc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prtc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== design/prtc_rule_eval.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prtc_rule_eval
// Compare unit: tests one rule against the packet under the active policy
// and gives the updated verdict and whether the scan ends here.
// ----------------------------------------------------------------------------
module prtc_rule_eval
   import prtc_pkg::*;
(
   input  wire rule_type   rule,
   input  wire pkt_type    pkt,
   input  wire logic [2:0] mode,
   input  wire logic       verdict_cur,
   output eval_type        result
);

   logic addr_hit;
   logic port_hit;
   logic proto_hit;
   logic is_port_proto;

   assign addr_hit = (rule.src_addr == 32'd0 || rule.src_addr == pkt.src_addr) &&
                     (rule.dst_addr == 32'd0 || rule.dst_addr == pkt.dst_addr);
   assign port_hit = (rule.source_port == 16'd0 || rule.source_port == pkt.source_port) &&
                     (rule.dest_port == 16'd0 || rule.dest_port == pkt.dest_port);
   assign proto_hit = (rule.proto == 8'd0 || rule.proto == pkt.proto);
   assign is_port_proto = (rule.proto == PROTO_TCP || rule.proto == PROTO_UDP);

   always_comb begin
      result.verdict = verdict_cur;
      result.stop    = 1'b0;
      unique case (mode)
         MODE_MATCH: begin
            if (addr_hit && proto_hit) begin
               result.verdict = rule.verdict;
               result.stop    = 1'b1;
            end
         end
         MODE_BLACK: begin
            if (addr_hit) begin
               // A wildcard protocol rule sets the verdict but lets later rules override.
               priority if (rule.proto == 8'd0) begin
                  result.verdict = rule.verdict;
               end else if (rule.proto == PROTO_ICMP) begin
                  result.verdict = rule.verdict;
                  result.stop    = 1'b1;
               end else if (is_port_proto) begin
                  if (port_hit) begin
                     result.verdict = rule.verdict;
                  end
                  result.stop = 1'b1;
               end else begin
                  result.verdict = 1'b0;
                  result.stop    = 1'b1;
               end
            end
         end
         MODE_WHITE: begin
            if (addr_hit) begin
               if (rule.proto == 8'd0 || rule.proto == PROTO_ICMP) begin
                  result.verdict = rule.verdict;
               end else if (is_port_proto && port_hit) begin
                  result.verdict = rule.verdict;
               end
            end
            result.stop = result.verdict;
         end
         default: begin
            result.stop = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/packet_rule_table_classifier_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_rule_table_classifier_core
// Ordered rule table with add, delete and three classification policies.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Ports
//  request   start & !busy       req_mode, req_src_ip .. req_rule_index
//  response  rsp_valid (1 cycle) rsp_verdict, rsp_status, rsp_rules_held
//
// Rules are kept in one RAM in arrival order, so the front of the table is
// the highest occupied address. Add and rejected items answer in the cycle
// after acceptance. A classify item reads one rule per cycle from the RAM,
// front first, and answers once a rule ends the scan or the last rule is read.
// A delete item moves the rules in front of the deleted one down one RAM
// entry per cycle and answers once the last of them has moved. Synchronous
// reset empties the table at once. The response is a one-cycle strobe and
// cannot be stalled.
//
module packet_rule_table_classifier_core
   import prtc_pkg::*;
#(
   parameter int unsigned MAX_RULES = PRTC_MAX_RULES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_mode,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [31:0] req_dst_ip,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [15:0] req_source_port,
   input  wire logic [15:0] req_dest_port,
   input  wire logic        req_rule_action,
   input  wire logic [4:0]  req_rule_index,
   output logic             rsp_valid,
   output logic             rsp_verdict,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_rules_held
);

   localparam int unsigned CNT_W  = $clog2(MAX_RULES + 1);
   localparam int unsigned ADDR_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int unsigned CMP_W  = (CNT_W > 5) ? CNT_W : 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [2:0]        mode_ff, mode_in;
   pkt_type           pkt_ff, pkt_in;
   logic [ADDR_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic              verdict_ff, verdict_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_verdict_ff, rsp_verdict_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [4:0]        rsp_held_ff, rsp_held_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_wr_addr;
   rule_type          ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   rule_type          ram_rd_data;

   rule_type          new_rule;
   logic [ADDR_W-1:0] last_addr;
   logic [ADDR_W-1:0] del_addr;
   logic              table_full;
   logic              bad_index;
   logic              default_verdict;
   eval_type          eval;

   prtc_ram #(
      .WIDTH ($bits(rule_type)),
      .DEPTH (MAX_RULES)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   prtc_rule_eval u_rule_eval (
      .rule        (ram_rd_data),
      .pkt         (pkt_ff),
      .mode        (mode_ff),
      .verdict_cur (verdict_ff),
      .result      (eval)
   );

   assign new_rule = '{
      src_addr:    req_src_ip,
      dst_addr:    req_dst_ip,
      proto:       req_protocol,
      source_port: req_source_port,
      dest_port:   req_dest_port,
      verdict:     req_rule_action
   };

   assign last_addr  = ADDR_W'(count_ff - CNT_W'(1));
   // Rule number n counts from the front, which is address count - n.
   assign del_addr   = ADDR_W'(CMP_W'(count_ff) - CMP_W'(req_rule_index));
   assign table_full = (count_ff == CNT_W'(MAX_RULES));
   assign bad_index  = (req_rule_index == 5'd0) ||
                       (CMP_W'(req_rule_index) > CMP_W'(count_ff));
   assign default_verdict = (req_mode != MODE_WHITE);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      mode_in        = mode_ff;
      pkt_in         = pkt_ff;
      scan_ptr_in    = scan_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = 1'b0;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_held_in    = rsp_held_ff;
      ram_we         = 1'b0;
      ram_wr_addr    = ADDR_W'(count_ff);
      ram_wr_data    = new_rule;
      ram_rd_addr    = last_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_mode == MODE_DELETE) begin
               ram_rd_addr = ADDR_W'(del_addr + ADDR_W'(1));
            end
            if (start) begin
               mode_in = req_mode;
               pkt_in  = '{
                  src_addr:    req_src_ip,
                  dst_addr:    req_dst_ip,
                  proto:       req_protocol,
                  source_port: req_source_port,
                  dest_port:   req_dest_port
               };
               unique case (req_mode)
                  MODE_ADD: begin
                     rsp_valid_in   = 1'b1;
                     rsp_verdict_in = 1'b0;
                     if (table_full) begin
                        rsp_status_in = STATUS_FULL;
                        rsp_held_in   = 5'(count_ff);
                     end else begin
                        ram_we        = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = STATUS_OK;
                        rsp_held_in   = 5'(count_ff + CNT_W'(1));
                     end
                  end
                  MODE_DELETE: begin
                     if (bad_index) begin
                        rsp_valid_in   = 1'b1;
                        rsp_verdict_in = 1'b0;
                        rsp_status_in  = STATUS_BAD_INDEX;
                        rsp_held_in    = 5'(count_ff);
                     end else if (del_addr == last_addr) begin
                        // The front rule goes: nothing in front of it to move.
                        count_in       = count_ff - CNT_W'(1);
                        rsp_valid_in   = 1'b1;
                        rsp_verdict_in = 1'b0;
                        rsp_status_in  = STATUS_OK;
                        rsp_held_in    = 5'(count_ff - CNT_W'(1));
                     end else begin
                        wr_ptr_in = del_addr;
                        state_in  = ST_SHIFT;
                     end
                  end
                  MODE_MATCH, MODE_BLACK, MODE_WHITE: begin
                     if (count_ff == CNT_W'(0)) begin
                        rsp_valid_in   = 1'b1;
                        rsp_verdict_in = default_verdict;
                        rsp_status_in  = STATUS_OK;
                        rsp_held_in    = 5'(count_ff);
                     end else begin
                        verdict_in  = default_verdict;
                        scan_ptr_in = last_addr;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_verdict_in = 1'b0;
                     rsp_status_in  = STATUS_OK;
                     rsp_held_in    = 5'(count_ff);
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // Read data holds the entry one above the write pointer.
            ram_we      = 1'b1;
            ram_wr_addr = wr_ptr_ff;
            ram_wr_data = ram_rd_data;
            ram_rd_addr = ADDR_W'(wr_ptr_ff + ADDR_W'(2));
            if (ADDR_W'(wr_ptr_ff + ADDR_W'(1)) == last_addr) begin
               count_in       = count_ff - CNT_W'(1);
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = 1'b0;
               rsp_status_in  = STATUS_OK;
               rsp_held_in    = 5'(count_ff - CNT_W'(1));
               state_in       = ST_IDLE;
            end else begin
               wr_ptr_in = ADDR_W'(wr_ptr_ff + ADDR_W'(1));
            end
         end
         ST_SCAN: begin
            ram_rd_addr = ADDR_W'(scan_ptr_ff - ADDR_W'(1));
            if (eval.stop || scan_ptr_ff == ADDR_W'(0)) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = eval.verdict;
               rsp_status_in  = STATUS_OK;
               rsp_held_in    = 5'(count_ff);
               state_in       = ST_IDLE;
            end else begin
               scan_ptr_in = ADDR_W'(scan_ptr_ff - ADDR_W'(1));
               verdict_in  = eval.verdict;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      pkt_ff         <= pkt_in;
      scan_ptr_ff    <= scan_ptr_in;
      wr_ptr_ff      <= wr_ptr_in;
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_held_ff    <= rsp_held_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_verdict    = rsp_verdict_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_rules_held = rsp_held_ff;

endmodule
`default_nettype wire
